// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define JMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define JMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jmq_pkg.sv =====
`default_nettype none
package jmq_pkg;

    localparam int IN_W   = 32;   // Q16.16 state fields
    localparam int DUR_W  = 24;   // Q8.16 duration
    localparam int COEF_W = 64;   // coefficient width

    // s_tdata layout
    localparam int TDATA_IN_W = 6 * IN_W + DUR_W;
    localparam int P0_LSB = 0;
    localparam int V0_LSB = IN_W;
    localparam int A0_LSB = 2 * IN_W;
    localparam int PE_LSB = 3 * IN_W;
    localparam int VE_LSB = 4 * IN_W;
    localparam int AE_LSB = 5 * IN_W;
    localparam int DU_LSB = 6 * IN_W;

    // m_tdata / m_tuser layout
    localparam int TDATA_OUT_W = 6 * COEF_W;
    localparam int TUSER_OUT_W = 2;
    localparam int TUSER_SAT   = 0;
    localparam int TUSER_INV   = 1;

    // Width of the solved-system numerators x3..x5
    localparam int XW = 88;

    // Divider: one quotient bit per stage plus entry and exit stages
    localparam int DIV_LAT = COEF_W + 2;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              sat;
    } div_out_t;

endpackage
`default_nettype wire

// ===== src/jmq_mul.sv =====
`default_nettype none
// x * d, two stages: 32-bit limb products, then the shifted sum.
module jmq_mul #(
    parameter int XW = 32
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [XW-1:0]                x,
    input  logic [jmq_pkg::DUR_W-1:0]           d,
    output logic signed [XW+jmq_pkg::DUR_W-1:0] prod
);
    import jmq_pkg::*;

    localparam int LIMBS = (XW + 31) / 32;
    localparam int XPW   = 32 * LIMBS;
    localparam int PPW   = 33 + DUR_W + 1;
    localparam int ACCW  = XPW + DUR_W + 2;
    localparam int PW    = XW + DUR_W;

    logic signed [XPW-1:0]  xp;
    logic signed [32:0]     limb_w  [LIMBS];
    logic signed [PPW-1:0]  pp_next [LIMBS];
    logic signed [PPW-1:0]  pp_reg  [LIMBS];
    logic signed [ACCW-1:0] acc_w;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   prod_reg;

    assign xp = XPW'(x);

    always_comb begin
        for (int i = 0; i < LIMBS; i++) begin
            // only the top limb carries the sign
            if (i == LIMBS - 1) begin
                limb_w[i] = {xp[32*i+31], xp[32*i +: 32]};
            end else begin
                limb_w[i] = {1'b0, xp[32*i +: 32]};
            end
            pp_next[i] = limb_w[i] * $signed({1'b0, d});
        end
    end

    always_comb begin
        acc_w = '0;
        for (int i = 0; i < LIMBS; i++) begin
            acc_w = acc_w + (ACCW'(pp_reg[i]) <<< (32 * i));
        end
        prod_next = acc_w[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg   <= pp_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== src/jmq_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage, with clamp and sign.
// q = floor(num / den), limited to signed COEF_W bits.
module jmq_div #(
    parameter int NW = 120,
    parameter int DW = 73
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [NW-1:0]          num,
    input  logic [DW-1:0]          den,
    input  logic                   neg,
    output jmq_pkg::div_out_t      res
);
    import jmq_pkg::*;

    localparam int STEPS = COEF_W;
    localparam int HW    = NW - STEPS;
    localparam int CW    = (HW > DW) ? HW : DW;

    logic [CW-1:0]     hi_ext;
    logic [CW-1:0]     den_ext;

    logic [DW-1:0]     rem_next [0:STEPS];
    logic [STEPS-1:0]  low_next [0:STEPS];
    logic [STEPS-1:0]  q_next   [0:STEPS];
    logic              big_next [0:STEPS];
    logic [DW:0]       trial_w  [1:STEPS];
    logic              ge_w     [1:STEPS];

    logic [DW-1:0]     rem_reg  [0:STEPS];
    logic [STEPS-1:0]  low_reg  [0:STEPS];
    logic [STEPS-1:0]  q_reg    [0:STEPS];
    logic [DW-1:0]     den_reg  [0:STEPS];
    logic              neg_reg  [0:STEPS];
    logic              big_reg  [0:STEPS];

    logic [STEPS-1:0]  q_fin;
    logic              over_w;
    div_out_t          res_next;
    div_out_t          res_reg;

    assign hi_ext  = CW'(num[NW-1:STEPS]);
    assign den_ext = CW'(den);

    always_comb begin
        // entry: quotient bits above the result width mean overflow
        big_next[0] = (hi_ext >= den_ext);
        rem_next[0] = hi_ext[DW-1:0];
        low_next[0] = num[STEPS-1:0];
        q_next[0]   = '0;
        for (int k = 1; k <= STEPS; k++) begin
            trial_w[k]  = {rem_reg[k-1], low_reg[k-1][STEPS-1]};
            ge_w[k]     = (trial_w[k] >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge_w[k] ? DW'(trial_w[k] - {1'b0, den_reg[k-1]})
                                  : trial_w[k][DW-1:0];
            low_next[k] = {low_reg[k-1][STEPS-2:0], 1'b0};
            q_next[k]   = {q_reg[k-1][STEPS-2:0], ge_w[k]};
            big_next[k] = big_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next[0];
            low_reg[0] <= low_next[0];
            q_reg[0]   <= q_next[0];
            big_reg[0] <= big_next[0];
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            for (int k = 1; k <= STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
                big_reg[k] <= big_next[k];
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    // exit: clamp to the signed range, then apply the sign
    always_comb begin
        q_fin  = q_reg[STEPS];
        over_w = big_reg[STEPS] ||
                 (q_fin[STEPS-1] && (!neg_reg[STEPS] || (q_fin[STEPS-2:0] != '0)));
        res_next.sat = over_w;
        if (over_w) begin
            res_next.coef = neg_reg[STEPS] ? COEF_MIN : COEF_MAX;
        end else begin
            res_next.coef = neg_reg[STEPS] ? (~q_fin + 1'b1) : q_fin;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ===== src/min_jerk_quintic_coeffs_top.sv =====
`default_nettype none
// Channel   Dir  Beat content (lowest bits first)                       Handshake
// s_        in   start_pos, start_vel, start_acc, end_pos, end_vel,      s_tvalid/s_tready
//                end_acc (32b each), duration (24b)
// m_        out  coef0..coef5 (64b each); tuser: saturated, invalid     m_tvalid/m_tready
//
// One beat per cycle sustained while the skid slot is free; every beat yields one result beat.
// From input accept to m_tvalid the path is ten front-end stages (the
// first loads at the accept edge), 66 divider stages, then the output register.
// aresetn (synchronous) clears only the valid bits, those of the output buffer included.
// The whole pipeline holds when the output skid slot is occupied; a result
// waiting on m_tready never blocks input until a second one is behind it.
module min_jerk_quintic_coeffs_top #(
    parameter int COEF_FRAC_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
    input  logic [jmq_pkg::TDATA_IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // coef0, coef1, coef2, coef3, coef4, coef5
    output logic [jmq_pkg::TDATA_OUT_W-1:0]      m_tdata,
    // saturated, invalid
    output logic [jmq_pkg::TUSER_OUT_W-1:0]      m_tuser
);
    import jmq_pkg::*;

    localparam int F          = COEF_FRAC_BITS;
    localparam int PIPE_DEPTH = 10 + DIV_LAT;
    localparam int ITEM_W     = TDATA_OUT_W + TUSER_OUT_W;

    // Numerator scale per coefficient: mag * 2^S + d^k over 2 * d^k
    // gives round-half-up of mag * 2^(S-1) / d^k.
    localparam int S3  = F;
    localparam int S4  = F + 16;
    localparam int S5  = F + 32;
    localparam int NW3 = XW + S3 + 1;
    localparam int NW4 = XW + S4 + 1;
    localparam int NW5 = XW + S5 + 1;
    localparam int DW3 = 3 * DUR_W + 1;
    localparam int DW4 = 4 * DUR_W + 1;
    localparam int DW5 = 5 * DUR_W + 1;

    typedef struct packed {
        logic signed [IN_W-1:0] p0;
        logic signed [IN_W-1:0] v0;
        logic signed [IN_W-1:0] a0;
        logic                   inv;
    } side_t;

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    logic                  en;
    logic [PIPE_DEPTH:1]   vld_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic [ITEM_W-1:0]     out_item_reg;
    logic [ITEM_W-1:0]     skid_item_reg;
    logic [ITEM_W-1:0]     push_item;
    logic                  push;

    // pipeline advances whenever the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[PIPE_DEPTH];

    // ---------------------------------------------------------------
    // Stage 1: register inputs, form the end-start differences
    // ---------------------------------------------------------------
    logic signed [IN_W-1:0] in_p0, in_v0, in_a0, in_pe, in_ve, in_ae;
    logic [DUR_W-1:0]       in_du;

    assign in_p0 = s_tdata[P0_LSB +: IN_W];
    assign in_v0 = s_tdata[V0_LSB +: IN_W];
    assign in_a0 = s_tdata[A0_LSB +: IN_W];
    assign in_pe = s_tdata[PE_LSB +: IN_W];
    assign in_ve = s_tdata[VE_LSB +: IN_W];
    assign in_ae = s_tdata[AE_LSB +: IN_W];
    assign in_du = s_tdata[DU_LSB +: DUR_W];

    logic signed [IN_W-1:0] v0_s1_reg, a0_s1_reg;
    logic signed [IN_W:0]   dp_reg [1:3];
    logic signed [IN_W:0]   dv_reg [1:3];
    logic signed [IN_W:0]   da_s1_reg;
    logic [DUR_W-1:0]       d_reg  [1:7];
    side_t                  side_reg [1:PIPE_DEPTH];
    side_t                  side_next;

    assign side_next = '{p0: in_p0, v0: in_v0, a0: in_a0, inv: (in_du == '0)};

    // ---------------------------------------------------------------
    // Stages 2-3: v0*d, a0*d, (ae-a0)*d, d^2
    // ---------------------------------------------------------------
    logic signed [IN_W+DUR_W-1:0]   a_p, b_p;
    logic signed [IN_W+DUR_W:0]     c_p;
    logic signed [2*DUR_W:0]        d2_p;

    jmq_mul #(.XW(IN_W))    u_mul_a  (.aclk, .en, .x(v0_s1_reg), .d(d_reg[1]), .prod(a_p));
    jmq_mul #(.XW(IN_W))    u_mul_b  (.aclk, .en, .x(a0_s1_reg), .d(d_reg[1]), .prod(b_p));
    jmq_mul #(.XW(IN_W+1))  u_mul_c  (.aclk, .en, .x(da_s1_reg), .d(d_reg[1]), .prod(c_p));
    jmq_mul #(.XW(DUR_W+1)) u_mul_d2 (.aclk, .en, .x($signed({1'b0, d_reg[1]})),
                                      .d(d_reg[1]), .prod(d2_p));

    // ---------------------------------------------------------------
    // Stage 4: n1 = (ve-v0)*2^16 - a0*d ; partial n0 = (pe-p0)*2^33 - v0*d*2^17
    // ---------------------------------------------------------------
    localparam int N1W  = 58;
    localparam int N0AW = 74;
    localparam int N0W  = 82;

    logic signed [N1W-1:0]         n1_s4_reg;
    logic signed [N0AW-1:0]        n0a_reg [4:6];
    logic signed [IN_W+DUR_W-1:0]  b_s4_reg;
    logic signed [IN_W+DUR_W:0]    c_s4_reg;

    // ---------------------------------------------------------------
    // Stages 5-6: e1 = n1*d, a0*d^2, e2 = (ae-a0)*d^2 ; d^3 runs alongside
    // ---------------------------------------------------------------
    logic signed [N1W+DUR_W-1:0]     e1_p;
    logic signed [IN_W+2*DUR_W-1:0]  b2_p;
    logic signed [IN_W+2*DUR_W:0]    e2_p;
    logic signed [3*DUR_W:0]         d3_p;
    logic signed [4*DUR_W:0]         d4_p;
    logic signed [5*DUR_W:0]         d5_p;

    jmq_mul #(.XW(N1W))          u_mul_e1 (.aclk, .en, .x(n1_s4_reg), .d(d_reg[4]),
                                           .prod(e1_p));
    jmq_mul #(.XW(IN_W+DUR_W))   u_mul_b2 (.aclk, .en, .x(b_s4_reg),  .d(d_reg[4]),
                                           .prod(b2_p));
    jmq_mul #(.XW(IN_W+DUR_W+1)) u_mul_e2 (.aclk, .en, .x(c_s4_reg),  .d(d_reg[4]),
                                           .prod(e2_p));

    // powers of d: d^3 at stage 5, d^4 at 7, d^5 at 9
    jmq_mul #(.XW(2*DUR_W+1)) u_mul_d3 (.aclk, .en, .x(d2_p), .d(d_reg[3]), .prod(d3_p));
    jmq_mul #(.XW(3*DUR_W+1)) u_mul_d4 (.aclk, .en, .x(d3_p), .d(d_reg[5]), .prod(d4_p));
    jmq_mul #(.XW(4*DUR_W+1)) u_mul_d5 (.aclk, .en, .x(d4_p), .d(d_reg[7]), .prod(d5_p));

    logic [3*DUR_W-1:0] d3_reg [6:9];
    logic [4*DUR_W-1:0] d4_reg [8:9];

    // ---------------------------------------------------------------
    // Stage 7: n0 final ; stage 8: x3, x4, x5
    // ---------------------------------------------------------------
    logic signed [N0W-1:0] n0_s7_reg, e1_s7_reg, e2_s7_reg;
    logic signed [XW-1:0]  n0_x, e1_x, e2_x;
    logic signed [XW-1:0]  x3_next, x4_next, x5_next;
    logic signed [XW-1:0]  x3_reg, x4_reg, x5_reg;

    assign n0_x = XW'(n0_s7_reg);
    assign e1_x = XW'(e1_s7_reg);
    assign e2_x = XW'(e2_s7_reg);

    // closed-form inverse of the T-power matrix, scaled to integers
    assign x3_next = (n0_x <<< 3) + (n0_x <<< 1) - (e1_x <<< 3) + e2_x;
    assign x4_next = (e1_x <<< 4) - (e1_x <<< 1) - (n0_x <<< 4) + n0_x - (e2_x <<< 1);
    assign x5_next = (n0_x <<< 2) + (n0_x <<< 1) - (e1_x <<< 2) - (e1_x <<< 1) + e2_x;

    // ---------------------------------------------------------------
    // Stage 9: sign and magnitude ; stage 10: numerator and divisor
    // ---------------------------------------------------------------
    logic [XW-1:0]  mag3_reg, mag4_reg, mag5_reg;
    logic           neg3_reg, neg4_reg, neg5_reg;
    logic           neg3_s10_reg, neg4_s10_reg, neg5_s10_reg;
    logic [NW3-1:0] num3_reg;
    logic [NW4-1:0] num4_reg;
    logic [NW5-1:0] num5_reg;
    logic [DW3-1:0] den3_reg;
    logic [DW4-1:0] den4_reg;
    logic [DW5-1:0] den5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            v0_s1_reg <= in_v0;
            a0_s1_reg <= in_a0;
            dp_reg[1] <= (IN_W+1)'(in_pe) - (IN_W+1)'(in_p0);
            dv_reg[1] <= (IN_W+1)'(in_ve) - (IN_W+1)'(in_v0);
            da_s1_reg <= (IN_W+1)'(in_ae) - (IN_W+1)'(in_a0);
            d_reg[1]  <= in_du;
            side_reg[1] <= side_next;
            for (int k = 2; k <= 7; k++) begin
                d_reg[k] <= d_reg[k-1];
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 2; k <= 3; k++) begin
                dp_reg[k] <= dp_reg[k-1];
                dv_reg[k] <= dv_reg[k-1];
            end

            // stage 4
            n1_s4_reg  <= (N1W'(dv_reg[3]) <<< 16) - N1W'(b_p);
            n0a_reg[4] <= (N0AW'(dp_reg[3]) <<< 33) - (N0AW'(a_p) <<< 17);
            b_s4_reg   <= b_p;
            c_s4_reg   <= c_p;
            n0a_reg[5] <= n0a_reg[4];
            n0a_reg[6] <= n0a_reg[5];

            // d^3 / d^4 alignment to stage 9
            d3_reg[6] <= d3_p[3*DUR_W-1:0];
            for (int k = 7; k <= 9; k++) begin
                d3_reg[k] <= d3_reg[k-1];
            end
            d4_reg[8] <= d4_p[4*DUR_W-1:0];
            d4_reg[9] <= d4_reg[8];

            // stage 7
            n0_s7_reg <= N0W'(n0a_reg[6]) - N0W'(b2_p);
            e1_s7_reg <= e1_p;
            e2_s7_reg <= N0W'(e2_p);

            // stage 8
            x3_reg <= x3_next;
            x4_reg <= x4_next;
            x5_reg <= x5_next;

            // stage 9
            neg3_reg <= x3_reg[XW-1];
            neg4_reg <= x4_reg[XW-1];
            neg5_reg <= x5_reg[XW-1];
            mag3_reg <= x3_reg[XW-1] ? -x3_reg : x3_reg;
            mag4_reg <= x4_reg[XW-1] ? -x4_reg : x4_reg;
            mag5_reg <= x5_reg[XW-1] ? -x5_reg : x5_reg;

            // stage 10
            num3_reg <= (NW3'(mag3_reg) << S3) + NW3'(d3_reg[9]);
            num4_reg <= (NW4'(mag4_reg) << S4) + NW4'(d4_reg[9]);
            num5_reg <= (NW5'(mag5_reg) << S5) + NW5'(d5_p[5*DUR_W-1:0]);
            den3_reg <= {d3_reg[9], 1'b0};
            den4_reg <= {d4_reg[9], 1'b0};
            den5_reg <= {d5_p[5*DUR_W-1:0], 1'b0};
            neg3_s10_reg <= neg3_reg;
            neg4_s10_reg <= neg4_reg;
            neg5_s10_reg <= neg5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stages 11-76: dividers
    // ---------------------------------------------------------------
    div_out_t res3, res4, res5;

    jmq_div #(.NW(NW3), .DW(DW3)) u_div3 (.aclk, .en, .num(num3_reg), .den(den3_reg),
                                          .neg(neg3_s10_reg), .res(res3));
    jmq_div #(.NW(NW4), .DW(DW4)) u_div4 (.aclk, .en, .num(num4_reg), .den(den4_reg),
                                          .neg(neg4_s10_reg), .res(res4));
    jmq_div #(.NW(NW5), .DW(DW5)) u_div5 (.aclk, .en, .num(num5_reg), .den(den5_reg),
                                          .neg(neg5_s10_reg), .res(res5));

    // ---------------------------------------------------------------
    // Result assembly: c0 = p0, c1 = v0 exact; c2 = a0/2, rounded
    // half away from zero when only 16 fraction bits remain.
    // ---------------------------------------------------------------
    side_t             side_out;
    logic [COEF_W-1:0] c0_w, c1_w, c2_w, c3_w, c4_w, c5_w;
    logic              sat_w;

    assign side_out = side_reg[PIPE_DEPTH];
    assign c0_w = COEF_W'(side_out.p0) <<< (F - 16);
    assign c1_w = COEF_W'(side_out.v0) <<< (F - 16);

    generate
        if (F > 16) begin : g_c2_shift
            assign c2_w = COEF_W'(side_out.a0) <<< (F - 17);
        end else begin : g_c2_round
            logic [IN_W:0]   a0_mag;
            logic [IN_W-1:0] a0_half;
            assign a0_mag  = side_out.a0[IN_W-1] ? -(IN_W+1)'(side_out.a0)
                                                 : (IN_W+1)'(side_out.a0);
            assign a0_half = IN_W'((a0_mag + 1'b1) >> 1);
            assign c2_w    = side_out.a0[IN_W-1] ? -COEF_W'(a0_half) : COEF_W'(a0_half);
        end
    endgenerate

    // zero duration: higher coefficients forced to zero, no saturation
    assign c3_w  = side_out.inv ? '0 : res3.coef;
    assign c4_w  = side_out.inv ? '0 : res4.coef;
    assign c5_w  = side_out.inv ? '0 : res5.coef;
    assign sat_w = !side_out.inv && (res3.sat || res4.sat || res5.sat);

    assign push_item = {side_out.inv, sat_w, c5_w, c4_w, c3_w, c2_w, c1_w, c0_w};

    // ---------------------------------------------------------------
    // Valid bits and two-entry output buffer (output register + skid)
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PIPE_DEPTH-1:1], s_tvalid};
            end
            if (skid_valid_reg) begin
                if (m_tready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_item_reg <= skid_item_reg;
            end
        end else if (out_valid_reg && !m_tready) begin
            skid_item_reg <= push_item;
        end else begin
            out_item_reg <= push_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg[TDATA_OUT_W-1:0];
    assign m_tuser  = out_item_reg[ITEM_W-1:TDATA_OUT_W];

endmodule
`default_nettype wire

// ===== src/jmq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module jmq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [jmq_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input logic [jmq_pkg::TUSER_OUT_W-1:0]    m_tuser
);
    import jmq_pkg::*;

    logic inv_beat;
    assign inv_beat = m_tvalid && m_tuser[TUSER_INV];

    // zero duration leaves the solved coefficients at zero
    `JMQ_ASSERT_IMPL(a_inv_zero, aclk, aresetn, inv_beat, m_tdata[TDATA_OUT_W-1:3*COEF_W] == '0, "invalid beat with nonzero coef3..coef5")

    // only the solved coefficients can clamp
    `JMQ_ASSERT_IMPL(a_inv_nosat, aclk, aresetn, inv_beat, !m_tuser[TUSER_SAT], "invalid beat flagged saturated")

    // input back-pressure only while a result is pending
    `JMQ_ASSERT(a_ready_cause, aclk, aresetn, s_tready || m_tvalid, "input stalled with no pending result")

    // a stalled result beat holds
    `JMQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed under stall")

    // an offered input beat stays offered until taken
    `JMQ_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid, "input beat withdrawn under stall")

endmodule

bind min_jerk_quintic_coeffs_top jmq_checker u_jmq_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_min_jerk_quintic_coeffs_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_min_jerk_quintic_coeffs_top;
    import jmq_pkg::*;

    localparam int FRAC     = 32;
    localparam int N_RAND   = 1550;
    localparam int WDOG_MAX = 20000;
    localparam int TAIL     = 120;   // longer than the pipeline

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [TDATA_OUT_W-1:0] coefs;
        logic [TUSER_OUT_W-1:0] flags;
    } traj_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;

    logic [TDATA_IN_W-1:0] stim_q[$];
    traj_t coef_q[$];
    int n_in_total = 0;
    int n_in_acc = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    always #6 aclk = ~aclk;

    min_jerk_quintic_coeffs_top #(.COEF_FRAC_BITS(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // round(x * 2^shl / (2^rsh * d^k)) to nearest, ties away from zero, clamp to 64 bits
    function automatic logic [63:0] round_clamp(input wide_t x, input int shl, input int rsh,
                                                input int k, input logic [23:0] d,
                                                inout bit sat);
        logic [255:0] mag, den, y;
        logic [63:0] lim;
        bit neg;
        neg = x[255];
        mag = neg ? -x : x;
        den = 256'd1;
        for (int i = 0; i < k; i++) den = den * {232'd0, d};
        y = ((mag << (shl + 1)) + (den << rsh)) >> (rsh + 1);
        y = y / den;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (y[255:64] != '0 || y[63:0] > lim) begin
            y = {192'd0, lim};
            sat = 1'b1;
        end
        return neg ? -y[63:0] : y[63:0];
    endfunction

    function automatic traj_t solve_quintic(input logic [TDATA_IN_W-1:0] beat);
        wide_t p0, v0, a0, pe, ve, ae, dd, n0, n1, e1, e2, x3, x4, x5;
        logic [23:0] d;
        bit sat;
        traj_t r;
        p0 = wide_t'($signed(beat[P0_LSB +: IN_W]));
        v0 = wide_t'($signed(beat[V0_LSB +: IN_W]));
        a0 = wide_t'($signed(beat[A0_LSB +: IN_W]));
        pe = wide_t'($signed(beat[PE_LSB +: IN_W]));
        ve = wide_t'($signed(beat[VE_LSB +: IN_W]));
        ae = wide_t'($signed(beat[AE_LSB +: IN_W]));
        d  = beat[DU_LSB +: DUR_W];
        dd = {232'd0, d};
        sat = 1'b0;
        r.coefs[0*COEF_W +: COEF_W] = round_clamp(p0, FRAC, 16, 0, 24'd1, sat);
        r.coefs[1*COEF_W +: COEF_W] = round_clamp(v0, FRAC, 16, 0, 24'd1, sat);
        r.coefs[2*COEF_W +: COEF_W] = round_clamp(a0, FRAC, 17, 0, 24'd1, sat);
        if (d == '0) begin
            r.coefs[3*COEF_W +: 3*COEF_W] = '0;
            r.flags[TUSER_INV] = 1'b1;
        end else begin
            // d0 = n0/2^49, d1 = n1/2^32, d2 = (ae-a0)/2^16
            n0 = ((pe - p0) <<< 33) - ((v0 * dd) <<< 17) - a0 * dd * dd;
            n1 = ((ve - v0) <<< 16) - a0 * dd;
            e1 = n1 * dd;
            e2 = (ae - a0) * dd * dd;
            x3 = 10 * n0 - 8 * e1 + e2;
            x4 = -15 * n0 + 14 * e1 - 2 * e2;
            x5 = 6 * n0 - 6 * e1 + e2;
            r.coefs[3*COEF_W +: COEF_W] = round_clamp(x3, FRAC - 1, 0, 3, d, sat);
            r.coefs[4*COEF_W +: COEF_W] = round_clamp(x4, FRAC + 15, 0, 4, d, sat);
            r.coefs[5*COEF_W +: COEF_W] = round_clamp(x5, FRAC + 31, 0, 5, d, sat);
            r.flags[TUSER_INV] = 1'b0;
        end
        r.flags[TUSER_SAT] = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic add_stim(input logic [TDATA_IN_W-1:0] beat);
        stim_q.insert(stim_q.size(), beat);
    endtask

    function automatic logic [31:0] pick_state();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3, 4: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;  // near zero
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'($urandom_range(1, 255));
            2: return 24'hFF_FFFF;
            3, 4, 5: return 24'($urandom_range(24'h00_4000, 24'h08_0000));  // 0.25 s .. 8 s
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [TDATA_IN_W-1:0] make_beat(input logic [31:0] p0, v0, a0,
                                                         pe, ve, ae, input logic [23:0] d);
        return {d, ae, ve, pe, a0, v0, p0};
    endfunction

    // idle percentages by run phase
    function automatic int src_idle_pct();
        if (n_in_acc < n_in_total / 3) return 21;
        if (n_in_acc < 2 * n_in_total / 3) return 45;
        return 0;
    endfunction

    function automatic int sink_idle_pct();
        if (n_in_acc < n_in_total / 3) return 45;
        if (n_in_acc < 2 * n_in_total / 3) return 21;
        return 0;
    endfunction

    // driver: presents the next beat, or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                coef_q.insert(coef_q.size(), solve_quintic(s_tdata));
                n_in_acc++;
            end
            if (stim_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct()) begin
                s_tdata  <= stim_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure and result check
    always @(posedge aclk) begin
        traj_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct());
            if (m_tvalid && m_tready) begin
                if (coef_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[63:0], 64'd0);
                end else begin
                    want = coef_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_tdata[i*COEF_W +: COEF_W] !== want.coefs[i*COEF_W +: COEF_W])
                            report_mismatch($sformatf("coef%0d", i),
                                            m_tdata[i*COEF_W +: COEF_W],
                                            want.coefs[i*COEF_W +: COEF_W]);
                    if (m_tuser[TUSER_SAT] !== want.flags[TUSER_SAT])
                        report_mismatch("saturated", 64'(m_tuser[TUSER_SAT]),
                                        64'(want.flags[TUSER_SAT]));
                    if (m_tuser[TUSER_INV] !== want.flags[TUSER_INV])
                        report_mismatch("invalid", 64'(m_tuser[TUSER_INV]),
                                        64'(want.flags[TUSER_INV]));
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // directed: field extremes, zero/min/max duration, odd a0 values for a0/2
        add_stim(make_beat(0, 0, 0, 0, 0, 0, 24'h01_0000));
        add_stim(make_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF));
        add_stim(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
        add_stim(make_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1));
        add_stim(make_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1));
        add_stim(make_beat(32'h1234_5678, 32'hFFFF_0001, 32'd3,
                           32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 24'd0));
        add_stim(make_beat(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                           32'd0, 32'd0, 32'd0, 24'd0));
        add_stim(make_beat(0, 0, 0, 32'h0001_0000, 0, 0, 24'h01_0000));
        add_stim(make_beat(0, 0, 0, 32'hFFFF_0000, 0, 0, 24'h02_0000));
        add_stim(make_beat(0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 24'h00_8000));
        add_stim(make_beat(0, 0, 32'd1, 0, 0, 32'hFFFF_FFFF, 24'h03_0000));
        add_stim(make_beat(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFD, 32'd1,
                           32'hFFFF_FFFF, 32'd3, 24'd3));
        add_stim(make_beat(0, 0, 0, 32'd1, 0, 0, 24'hFF_FFFF));
        add_stim(make_beat(32'h0005_0000, 32'h0001_8000, 32'hFFFF_C000,
                           32'h0050_0000, 32'h0002_0000, 0, 24'h0A_0000));
        add_stim(make_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'hAA_AAAA));
        add_stim(make_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'h55_5555));
        for (int i = 0; i < N_RAND; i++)
            add_stim(make_beat(pick_state(), pick_state(), pick_state(),
                               pick_state(), pick_state(), pick_state(),
                               pick_duration()));
        n_in_total = stim_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (n_in_acc == n_in_total && coef_q.size() == 0);
        repeat (TAIL) @(posedge aclk);
        if (n_errors == 0 && coef_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== min_jerk_quintic_coeffs_top.f =====
+incdir+src
src/jmq_pkg.sv
src/jmq_mul.sv
src/jmq_div.sv
src/min_jerk_quintic_coeffs_top.sv
src/jmq_checker.sv
tb/sv/tb_min_jerk_quintic_coeffs_top.sv
